>>> src/turmite_grid_walker_defines.svh
// assertion macros for the grid walker
`ifndef TURMITE_GRID_WALKER_DEFINES_SVH
`define TURMITE_GRID_WALKER_DEFINES_SVH

// same-cycle implication
`define TGW_ASSERT_NOW(label, lhs, rhs, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (lhs) |-> (rhs)) \
      else $error(msg);

// next-cycle implication
`define TGW_ASSERT_NEXT(label, lhs, rhs, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (lhs) |=> (rhs)) \
      else $error(msg);

`endif

>>> src/twg_pkg.sv
`default_nettype none

package twg_pkg;

   localparam int GRID_MAX_W  = 128;
   localparam int GRID_MAX_H  = 128;
   localparam int MAX_COLOURS = 16;

   localparam int X_BITS    = $clog2(GRID_MAX_W);
   localparam int Y_BITS    = $clog2(GRID_MAX_H);
   localparam int ADDR_BITS = X_BITS + Y_BITS;
   localparam int CELLS     = GRID_MAX_W * GRID_MAX_H;

   localparam int CELL_BITS     = 4;
   localparam int POS_BITS      = 9;
   localparam int CNT_BITS      = 32;
   localparam int DIM_BITS      = 8;
   localparam int CC_BITS       = 5;
   localparam int RULE_BITS     = 16;
   localparam int READ_BITS     = 7;
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 16;
   localparam int REQ_DATA_BITS = 16;
   localparam int RSP_FIELD_BITS = 2 * POS_BITS + 2 + 1 + CELL_BITS + CNT_BITS + 1;
   localparam int RSP_DATA_BITS = ((RSP_FIELD_BITS + 7) / 8) * 8;
   localparam int RSP_PAD_BITS  = RSP_DATA_BITS - RSP_FIELD_BITS;

   localparam logic [DIM_BITS-1:0] W_LIMIT  = DIM_BITS'(GRID_MAX_W);
   localparam logic [DIM_BITS-1:0] H_LIMIT  = DIM_BITS'(GRID_MAX_H);
   localparam logic [CC_BITS-1:0]  CC_LIMIT = CC_BITS'(MAX_COLOURS);

   localparam logic                 MODE_RST  = 1'b0;
   localparam logic [CC_BITS-1:0]   CC_RST    = 5'd2;
   localparam logic [RULE_BITS-1:0] RULE_RST  = 16'd1;
   localparam logic [RULE_BITS-1:0] TABLE_RST = 16'd19353;
   localparam logic [DIM_BITS-1:0]  W_RST     = 8'd128;
   localparam logic [DIM_BITS-1:0]  H_RST     = 8'd128;
   localparam logic                 WRAP_RST  = 1'b1;
   localparam logic signed [POS_BITS-1:0] POS_X_RST = POS_BITS'(W_RST / 2);
   localparam logic signed [POS_BITS-1:0] POS_Y_RST = POS_BITS'(H_RST / 2);

   localparam logic [1:0] TURN_LEFT  = 2'd0;
   localparam logic [1:0] TURN_RIGHT = 2'd1;

   localparam logic [1:0] DIR_UP    = 2'd0;
   localparam logic [1:0] DIR_RIGHT = 2'd1;
   localparam logic [1:0] DIR_DOWN  = 2'd2;
   localparam logic [1:0] DIR_LEFT  = 2'd3;

   typedef enum logic [1:0] {
      OP_STEP    = 2'd0,
      OP_RESTART = 2'd1,
      OP_READ    = 2'd2,
      OP_NONE    = 2'd3
   } op_type;

   typedef enum logic [CSR_ADDR_BITS-1:0] {
      CSR_MODE   = 3'd0,
      CSR_CCOUNT = 3'd1,
      CSR_RULE   = 3'd2,
      CSR_TABLE  = 3'd3,
      CSR_WIDTH  = 3'd4,
      CSR_HEIGHT = 3'd5,
      CSR_WRAP   = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic accept;
      logic clear_en;
      logic commit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic clear_last;
   } dp_status_type;

   function automatic logic [DIM_BITS-1:0] eff_dim(input logic [DIM_BITS-1:0] d,
                                                   input logic [DIM_BITS-1:0] dmax);
      if (d == '0) return DIM_BITS'(1);
      if (d > dmax) return dmax;
      return d;
   endfunction

   function automatic logic [CC_BITS-1:0] eff_colours(input logic [CC_BITS-1:0] c);
      if (c == '0) return CC_BITS'(1);
      if (c > CC_LIMIT) return CC_LIMIT;
      return c;
   endfunction

   // v mod m for v up to MAX_COLOURS and m at least one
   function automatic logic [CELL_BITS-1:0] mod_small(input logic [CC_BITS-1:0] v,
                                                      input logic [CC_BITS-1:0] m);
      logic [CC_BITS-1:0]   r;
      logic [2*CC_BITS-1:0] prod;
      r = v;
      for (int q = 1; q <= MAX_COLOURS; q++) begin
         prod = (2*CC_BITS)'(q) * (2*CC_BITS)'(m);
         if (prod <= (2*CC_BITS)'(v)) begin
            r = CC_BITS'((2*CC_BITS)'(v) - prod);
         end
      end
      return r[CELL_BITS-1:0];
   endfunction

endpackage

`default_nettype wire

>>> src/twg_ctrl.sv
`default_nettype none

module twg_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire twg_pkg::op_type        req_op,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   input  wire twg_pkg::dp_status_type status,
   output twg_pkg::ctrl_cmd_type       cmd
);

   typedef enum logic [4:0] {
      ST_INIT  = 5'b00001,
      ST_IDLE  = 5'b00010,
      ST_FETCH = 5'b00100,
      ST_WIPE  = 5'b01000,
      ST_DONE  = 5'b10000
   } ctrl_state_type;

   ctrl_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           slot_free;

   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_INIT: begin
            cmd.clear_en = 1'b1;
            if (status.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               state_in   = (req_op == twg_pkg::OP_RESTART) ? ST_WIPE : ST_FETCH;
            end
         end
         ST_FETCH: begin
            state_in = ST_DONE;
         end
         ST_WIPE: begin
            cmd.clear_en = 1'b1;
            if (status.clear_last) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (slot_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase
   end

   always_comb begin
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

>>> src/twg_datapath.sv
`default_nettype none

module twg_datapath (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire twg_pkg::ctrl_cmd_type                 cmd,
   output twg_pkg::dp_status_type                     status,
   input  wire twg_pkg::op_type                       req_op,
   input  wire logic [twg_pkg::READ_BITS-1:0]         req_read_x,
   input  wire logic [twg_pkg::READ_BITS-1:0]         req_read_y,
   input  wire logic                                  csr_we,
   input  wire logic [twg_pkg::CSR_ADDR_BITS-1:0]     csr_addr,
   input  wire logic [twg_pkg::CSR_DATA_BITS-1:0]     csr_wdata,
   output logic [twg_pkg::RSP_DATA_BITS-1:0]          rsp_data
);

   // configuration
   logic                             mode_ff;
   logic [twg_pkg::CC_BITS-1:0]      ccount_ff;
   logic [twg_pkg::RULE_BITS-1:0]    rule_ff;
   logic [twg_pkg::RULE_BITS-1:0]    table_ff;
   logic [twg_pkg::DIM_BITS-1:0]     width_ff;
   logic [twg_pkg::DIM_BITS-1:0]     height_ff;
   logic                             wrap_ff;

   // walker state
   logic signed [twg_pkg::POS_BITS-1:0] pos_x_ff, pos_x_in;
   logic signed [twg_pkg::POS_BITS-1:0] pos_y_ff, pos_y_in;
   logic [1:0]                          dir_ff, dir_in;
   logic                                mstate_ff, mstate_in;
   logic [twg_pkg::CNT_BITS-1:0]        cnt_ff, cnt_in;
   logic [twg_pkg::CELL_BITS-1:0]       colour_ff, colour_in;

   // per-item latches and memory
   twg_pkg::op_type                     op_ff;
   logic [twg_pkg::ADDR_BITS-1:0]       addr_ff, addr_in;
   logic [twg_pkg::ADDR_BITS-1:0]       clr_addr_ff, clr_addr_in;
   logic [twg_pkg::CELL_BITS-1:0]       rd_data_ff;
   logic [twg_pkg::CELL_BITS-1:0]       cell_mem [twg_pkg::CELLS];

   logic [twg_pkg::DIM_BITS-1:0]        eff_w, eff_h;
   logic [twg_pkg::CC_BITS-1:0]         eff_cc;
   logic signed [twg_pkg::POS_BITS-1:0] w_s, h_s;
   logic                                cur_in;
   logic                                new_in;
   logic [twg_pkg::CELL_BITS-1:0]       written;
   logic [1:0]                          turn;
   logic                                nstate;
   logic [3:0]                          nib;
   logic [1:0]                          ndir;
   logic signed [twg_pkg::POS_BITS-1:0] nx, ny, wx, wy;
   logic                                wr_en;

   assign eff_w  = twg_pkg::eff_dim(width_ff, twg_pkg::W_LIMIT);
   assign eff_h  = twg_pkg::eff_dim(height_ff, twg_pkg::H_LIMIT);
   assign eff_cc = twg_pkg::eff_colours(ccount_ff);
   assign w_s    = $signed({1'b0, eff_w});
   assign h_s    = $signed({1'b0, eff_h});

   assign cur_in = !pos_x_ff[twg_pkg::POS_BITS-1] && !pos_y_ff[twg_pkg::POS_BITS-1]
                   && (pos_x_ff < w_s) && (pos_y_ff < h_s);

   assign status.clear_last = (clr_addr_ff == '1);

   // cell rule
   always_comb begin
      nib = table_ff[{mstate_ff, rd_data_ff[0], 2'b00} +: 4];
      if (mode_ff) begin
         written = {{(twg_pkg::CELL_BITS-1){1'b0}}, nib[0]};
         turn    = nib[2:1];
         nstate  = nib[3];
      end else begin
         written = twg_pkg::mod_small(twg_pkg::CC_BITS'(rd_data_ff) + 5'd1, eff_cc);
         turn    = {1'b0, rule_ff[rd_data_ff]};
         nstate  = mstate_ff;
      end
   end

   // turn, move, wrap
   always_comb begin
      if (turn == twg_pkg::TURN_RIGHT) begin
         ndir = dir_ff + 2'd1;
      end else if (turn == twg_pkg::TURN_LEFT) begin
         ndir = dir_ff - 2'd1;
      end else begin
         ndir = dir_ff;
      end
      nx = pos_x_ff;
      ny = pos_y_ff;
      unique case (ndir)
         twg_pkg::DIR_UP:    ny = pos_y_ff - 9'sd1;
         twg_pkg::DIR_RIGHT: nx = pos_x_ff + 9'sd1;
         twg_pkg::DIR_DOWN:  ny = pos_y_ff + 9'sd1;
         twg_pkg::DIR_LEFT:  nx = pos_x_ff - 9'sd1;
         default:            nx = pos_x_ff;
      endcase
      new_in = !nx[twg_pkg::POS_BITS-1] && !ny[twg_pkg::POS_BITS-1] && (nx < w_s) && (ny < h_s);
      wx = nx;
      wy = ny;
      if (wrap_ff && !new_in) begin
         if (nx[twg_pkg::POS_BITS-1]) begin
            wx = w_s - 9'sd1;
         end else if (nx >= w_s) begin
            wx = '0;
         end
         if (ny[twg_pkg::POS_BITS-1]) begin
            wy = h_s - 9'sd1;
         end else if (ny >= h_s) begin
            wy = '0;
         end
      end
   end

   // commit of one item
   always_comb begin
      pos_x_in  = pos_x_ff;
      pos_y_in  = pos_y_ff;
      dir_in    = dir_ff;
      mstate_in = mstate_ff;
      cnt_in    = cnt_ff;
      colour_in = colour_ff;
      wr_en     = 1'b0;
      if (cmd.commit) begin
         unique case (op_ff)
            twg_pkg::OP_STEP: begin
               cnt_in = cnt_ff + 32'd1;
               if (cur_in) begin
                  wr_en     = 1'b1;
                  pos_x_in  = wx;
                  pos_y_in  = wy;
                  dir_in    = ndir;
                  mstate_in = nstate;
                  colour_in = written;
               end else begin
                  colour_in = '0;
               end
            end
            twg_pkg::OP_RESTART: begin
               pos_x_in  = $signed({1'b0, eff_w >> 1});
               pos_y_in  = $signed({1'b0, eff_h >> 1});
               dir_in    = twg_pkg::DIR_UP;
               cnt_in    = '0;
               colour_in = '0;
            end
            twg_pkg::OP_READ: begin
               colour_in = rd_data_ff;
            end
            twg_pkg::OP_NONE: begin
               colour_in = '0;
            end
            default: begin
               colour_in = '0;
            end
         endcase
      end
   end

   always_comb begin
      if (req_op == twg_pkg::OP_READ) begin
         addr_in = {req_read_y, req_read_x};
      end else begin
         addr_in = {pos_y_ff[twg_pkg::Y_BITS-1:0], pos_x_ff[twg_pkg::X_BITS-1:0]};
      end
      clr_addr_in = cmd.clear_en ? clr_addr_ff + 1'b1 : clr_addr_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= twg_pkg::MODE_RST;
         ccount_ff <= twg_pkg::CC_RST;
         rule_ff   <= twg_pkg::RULE_RST;
         table_ff  <= twg_pkg::TABLE_RST;
         width_ff  <= twg_pkg::W_RST;
         height_ff <= twg_pkg::H_RST;
         wrap_ff   <= twg_pkg::WRAP_RST;
      end else if (csr_we) begin
         unique case (csr_addr)
            twg_pkg::CSR_MODE:   mode_ff   <= csr_wdata[0];
            twg_pkg::CSR_CCOUNT: ccount_ff <= csr_wdata[twg_pkg::CC_BITS-1:0];
            twg_pkg::CSR_RULE:   rule_ff   <= csr_wdata;
            twg_pkg::CSR_TABLE:  table_ff  <= csr_wdata;
            twg_pkg::CSR_WIDTH:  width_ff  <= csr_wdata[twg_pkg::DIM_BITS-1:0];
            twg_pkg::CSR_HEIGHT: height_ff <= csr_wdata[twg_pkg::DIM_BITS-1:0];
            twg_pkg::CSR_WRAP:   wrap_ff   <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_x_ff    <= twg_pkg::POS_X_RST;
         pos_y_ff    <= twg_pkg::POS_Y_RST;
         dir_ff      <= twg_pkg::DIR_UP;
         mstate_ff   <= 1'b0;
         cnt_ff      <= '0;
         clr_addr_ff <= '0;
      end else begin
         pos_x_ff    <= pos_x_in;
         pos_y_ff    <= pos_y_in;
         dir_ff      <= dir_in;
         mstate_ff   <= mstate_in;
         cnt_ff      <= cnt_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      colour_ff <= colour_in;
      if (cmd.accept) begin
         op_ff   <= req_op;
         addr_ff <= addr_in;
      end
   end

   // cell store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.clear_en) begin
         cell_mem[clr_addr_ff] <= '0;
      end else if (wr_en) begin
         cell_mem[addr_ff] <= written;
      end
      rd_data_ff <= cell_mem[addr_ff];
   end

   assign rsp_data = {{twg_pkg::RSP_PAD_BITS{1'b0}}, !cur_in, cnt_ff, colour_ff, mstate_ff,
                      dir_ff, pos_y_ff, pos_x_ff};

endmodule

`default_nettype wire

>>> src/turmite_grid_walker.sv
`default_nettype none

// Turmite grid walker on a 128 x 128 store of 4-bit cells. A step or a read
// beat goes from acceptance to its result through accept, store read and
// commit, the store read being the cell store's registered read port; commit
// waits while the last result is not yet taken. A restart beat clears the
// store one cell a cycle over all 16384 entries. After reset the same clearing
// pass runs before the first beat is accepted; configuration writes are taken
// at any time. One item is worked at a time; a new beat is accepted while the
// last result still waits on rsp_tready.

`include "turmite_grid_walker_defines.svh"

module turmite_grid_walker (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   // op[1:0], read_x[8:2], read_y[15:9]
   input  wire logic [twg_pkg::REQ_DATA_BITS-1:0]    req_tdata,
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   // ant_x[8:0], ant_y[17:9], heading[19:18], machine_state_out[20],
   // cell_colour[24:21], step_count[56:25], off_grid[57], zero fill
   output logic [twg_pkg::RSP_DATA_BITS-1:0]         rsp_tdata,
   input  wire logic                                 csr_we,
   input  wire logic [twg_pkg::CSR_ADDR_BITS-1:0]    csr_addr,
   input  wire logic [twg_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);

   twg_pkg::ctrl_cmd_type  cmd;
   twg_pkg::dp_status_type status;
   twg_pkg::op_type        req_op;

   assign req_op = twg_pkg::op_type'(req_tdata[1:0]);

   twg_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_op     (req_op),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   twg_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_op     (req_op),
      .req_read_x (req_tdata[8:2]),
      .req_read_y (req_tdata[15:9]),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .rsp_data   (rsp_tdata)
   );

   `TGW_ASSERT_NOW(a_no_commit_in_clear, cmd.commit, !cmd.clear_en, "commit during clear")
   `TGW_ASSERT_NEXT(a_one_item_at_once, cmd.accept, !req_tready, "second beat taken early")
   `TGW_ASSERT_NEXT(a_commit_shows_result, cmd.commit, rsp_tvalid, "committed result lost")

endmodule

`default_nettype wire
